FILE: rtl/cdat_pkg.sv
`timescale 1ns / 1ps
package cdat_pkg;
	localparam logic [1:0] OP_REPORT = 2'd0;
	localparam logic [1:0] OP_TICK   = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;
	localparam int KEY_W = 33;
	localparam int CNT_W = 24;
	localparam int SUM_W = 48;
	localparam int AVG_W = 32;
	localparam int TIME_W = 40;
	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
	localparam logic [AVG_W-1:0] AVG_MAX = {AVG_W{1'b1}};
	localparam logic [0:0] REG_WINDOW = 1'b0;
	localparam logic [0:0] REG_MINREC = 1'b1;
	typedef struct packed {
		logic start;
		logic [SUM_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} div_req_t;
	typedef struct packed {
		logic busy;
		logic done;
		logic [AVG_W-1:0] quotient;
	} div_rsp_t;
endpackage

FILE: rtl/cdat_ram.sv
`timescale 1ns / 1ps
module cdat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

FILE: rtl/cdat_div.sv
`timescale 1ns / 1ps
module cdat_div (
	input  logic               clk,
	input  logic               arst_n,
	input  cdat_pkg::div_req_t req,
	output cdat_pkg::div_rsp_t rsp
);
	import cdat_pkg::*;
	// restoring divider, one quotient bit per cycle, saturated to 32 bits
	logic [SUM_W-1:0] quo_q;
	logic [CNT_W:0]   rem_q;
	logic [CNT_W-1:0] dvs_q;
	logic [5:0]       cnt_q;
	logic             busy_q, done_q;
	logic [CNT_W:0]   trial;
	logic [CNT_W:0]   diff;
	assign trial = {rem_q[CNT_W-1:0], quo_q[SUM_W-1]};
	assign diff = trial - {1'b0, dvs_q};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'(SUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= (req.divisor == '0) ? CNT_W'(1) : req.divisor;
		end else if (busy_q) begin
			if (!diff[CNT_W]) begin
				rem_q <= diff;
				quo_q <= {quo_q[SUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[SUM_W-2:0], 1'b0};
			end
		end
	end
	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quotient = (quo_q[SUM_W-1:AVG_W] != '0) ? AVG_MAX : quo_q[AVG_W-1:0];
endmodule

FILE: rtl/channel_duration_average_table_core.sv
`timescale 1ns / 1ps
// Channel duration average table.
// Input channel: in_valid/in_stall with operation, range_start, range_stop,
// duration_ms, now_ms. Output channel: out_valid/out_stall with
// transmission_ok, average_found, window_closed, table_full; one result
// transfer per input transfer, in order.
// APB port: learning_window_ms at 0x0, min_recording_ms at 0x4.
// An item is walked over the table one entry at a time (RAM read, then
// compare/update) for report and query.
// A tick that closes the window runs the shared serial divider for each
// used entry in turn. in_stall is high while an item is in work; a
// finished result waits in the output register, and the next item holds in
// its last cycle until that result is taken. A stalled result holds.
// Reset clears the used bits, learned flag, last close time,
// and the registers to their defaults; table contents need no clearing.
module channel_duration_average_table_core #(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [32:0] range_start,
	input  logic [32:0] range_stop,
	input  logic [31:0] duration_ms,
	input  logic [39:0] now_ms,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        transmission_ok,
	output logic        average_found,
	output logic        window_closed,
	output logic        table_full,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import cdat_pkg::*;
	localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int IW = AW + 1;
	localparam logic [IW-1:0] LAST = IW'(TABLE_ENTRIES - 1);
	localparam logic [2:0] ST_IDLE = 3'd0, ST_READ = 3'd1, ST_EVAL = 3'd2,
		ST_DIV = 3'd3, ST_DIVW = 3'd4, ST_INS = 3'd5, ST_OUT = 3'd6;

	logic [31:0] win_q, minrec_q;
	logic [2:0] st_q;
	logic [IW-1:0] idx_q;
	logic [1:0] op_q;
	logic [KEY_W-1:0] lo_q, hi_q;
	logic [31:0] dur_q;
	logic [TIME_W-1:0] now_q, last_q;
	logic learned_q;
	logic [TABLE_ENTRIES-1:0] acc_used_q, avg_used_q;
	logic free_found_q;
	logic [AW-1:0] free_q;
	logic ok_q, found_q, closed_q, full_q, ovalid_q;

	logic [AW-1:0] ridx;
	assign ridx = idx_q[AW-1:0];

	logic acc_we, avg_we;
	logic [AW-1:0] acc_wa;
	logic [2*KEY_W-1:0] acc_key_wd, acc_key_rd, avg_key_rd;
	logic [CNT_W+SUM_W-1:0] acc_val_wd, acc_val_rd;
	logic [AVG_W-1:0] avg_rd;
	div_req_t div_req;
	div_rsp_t div_rsp;

	cdat_ram #(.WIDTH(2*KEY_W), .DEPTH(TABLE_ENTRIES)) u_acc_key (.clk, .we(acc_we),
		.waddr(acc_wa), .wdata(acc_key_wd), .raddr(ridx), .rdata(acc_key_rd));
	cdat_ram #(.WIDTH(CNT_W+SUM_W), .DEPTH(TABLE_ENTRIES)) u_acc_val (.clk, .we(acc_we),
		.waddr(acc_wa), .wdata(acc_val_wd), .raddr(ridx), .rdata(acc_val_rd));
	cdat_ram #(.WIDTH(2*KEY_W), .DEPTH(TABLE_ENTRIES)) u_avg_key (.clk, .we(avg_we),
		.waddr(ridx), .wdata(acc_key_rd), .raddr(ridx), .rdata(avg_key_rd));
	cdat_ram #(.WIDTH(AVG_W), .DEPTH(TABLE_ENTRIES)) u_avg_dur (.clk, .we(avg_we),
		.waddr(ridx), .wdata(div_rsp.quotient), .raddr(ridx), .rdata(avg_rd));

	cdat_div u_div (.clk, .arst_n, .req(div_req), .rsp(div_rsp));

	logic [CNT_W-1:0] rd_cnt;
	logic [SUM_W-1:0] rd_sum;
	logic [SUM_W:0] sum_ext;
	logic key_hit, acc_hit, avg_hit;
	logic [TIME_W:0] close_at;
	assign rd_cnt = acc_val_rd[CNT_W+SUM_W-1:SUM_W];
	assign rd_sum = acc_val_rd[SUM_W-1:0];
	assign sum_ext = {1'b0, rd_sum} + (SUM_W+1)'(dur_q);
	assign key_hit = acc_key_rd == {lo_q, hi_q};
	assign acc_hit = acc_used_q[ridx] && key_hit;
	assign avg_hit = avg_used_q[ridx] && (avg_key_rd == {lo_q, hi_q});
	assign close_at = {1'b0, last_q} + (TIME_W+1)'(win_q);

	always_comb begin
		acc_we = 1'b0;
		acc_wa = ridx;
		acc_key_wd = {lo_q, hi_q};
		acc_val_wd = {CNT_W'(1), SUM_W'(dur_q)};
		avg_we = (st_q == ST_DIVW) && div_rsp.done;
		div_req.start = (st_q == ST_DIV) && acc_used_q[ridx];
		div_req.dividend = rd_sum;
		div_req.divisor = rd_cnt;
		if (st_q == ST_EVAL && op_q == OP_REPORT && acc_hit) begin
			acc_we = 1'b1;
			acc_val_wd = {(rd_cnt == COUNT_MAX) ? rd_cnt : rd_cnt + CNT_W'(1),
				sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0]};
			acc_key_wd = acc_key_rd;
		end else if (st_q == ST_INS) begin
			acc_we = 1'b1;
			acc_wa = free_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			idx_q <= '0;
			learned_q <= 1'b0;
			last_q <= '0;
			acc_used_q <= '0;
			avg_used_q <= '0;
			ovalid_q <= 1'b0;
			free_found_q <= 1'b0;
			free_q <= '0;
			win_q <= 32'd60000;
			minrec_q <= 32'd1000;
		end else begin
			if (psel && penable && pwrite) begin
				if (paddr[2] == REG_WINDOW) win_q <= pwdata;
				else minrec_q <= pwdata;
			end
			if (st_q == ST_OUT && (!ovalid_q || !out_stall)) ovalid_q <= 1'b1;
			else if (!out_stall) ovalid_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: if (in_valid) begin
					idx_q <= '0;
					free_found_q <= 1'b0;
					if (operation == OP_TICK) begin
						st_q <= ({1'b0, now_ms} >= close_at) ? ST_READ : ST_OUT;
					end else if (operation == OP_REPORT || operation == OP_QUERY) begin
						st_q <= ST_READ;
					end else st_q <= ST_OUT;
				end
				ST_READ: st_q <= (op_q == OP_TICK) ? ST_DIV : ST_EVAL;
				ST_EVAL: begin
					if (op_q == OP_REPORT && !acc_used_q[ridx] && !free_found_q) begin
						free_found_q <= 1'b1;
						free_q <= ridx;
					end
					if ((op_q == OP_REPORT && acc_hit) || (op_q == OP_QUERY && avg_hit))
						st_q <= ST_OUT;
					else if (idx_q == LAST)
						st_q <= (op_q == OP_REPORT &&
							(free_found_q || !acc_used_q[ridx])) ? ST_INS : ST_OUT;
					else begin
						idx_q <= idx_q + IW'(1);
						st_q <= ST_READ;
					end
				end
				ST_INS: begin
					acc_used_q[free_q] <= 1'b1;
					st_q <= ST_OUT;
				end
				ST_DIV: begin
					avg_used_q[ridx] <= acc_used_q[ridx];
					if (acc_used_q[ridx]) st_q <= ST_DIVW;
					else if (idx_q == LAST) begin
						acc_used_q <= '0;
						learned_q <= 1'b1;
						last_q <= now_q;
						st_q <= ST_OUT;
					end else begin
						idx_q <= idx_q + IW'(1);
						st_q <= ST_READ;
					end
				end
				ST_DIVW: if (div_rsp.done) begin
					if (idx_q == LAST) begin
						acc_used_q <= '0;
						learned_q <= 1'b1;
						last_q <= now_q;
						st_q <= ST_OUT;
					end else begin
						idx_q <= idx_q + IW'(1);
						st_q <= ST_READ;
					end
				end
				ST_OUT: if (!ovalid_q || !out_stall) begin
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && in_valid) begin
			op_q <= operation;
			lo_q <= range_start;
			hi_q <= range_stop;
			dur_q <= duration_ms;
			now_q <= now_ms;
			ok_q <= 1'b0;
			found_q <= 1'b0;
			closed_q <= (operation == OP_TICK) && ({1'b0, now_ms} >= close_at);
			full_q <= 1'b0;
		end
		if (st_q == ST_EVAL && op_q == OP_QUERY) begin
			if (avg_hit) begin
				found_q <= 1'b1;
				ok_q <= avg_rd >= minrec_q;
			end else if (idx_q == LAST) ok_q <= learned_q;
		end
		if (st_q == ST_EVAL && op_q == OP_REPORT && !acc_hit && idx_q == LAST &&
			!free_found_q && acc_used_q[ridx]) full_q <= 1'b1;
		if (st_q == ST_OUT && (!ovalid_q || !out_stall)) begin
			transmission_ok <= ok_q;
			average_found <= found_q;
			window_closed <= closed_q;
			table_full <= full_q;
		end
	end

	assign in_stall = st_q != ST_IDLE;
	assign out_valid = ovalid_q;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_MINREC) ? minrec_q : win_q;

	a_div_only_tick: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> op_q == OP_TICK) else $error("divider started outside tick");
	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy) else $error("divider restarted while busy");
	a_one_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $countones({average_found, window_closed, table_full}) <= 1)
		else $error("result flags overlap");
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> st_q != ST_IDLE) else $error("accept lost");
endmodule

FILE: tb/sv/channel_duration_average_table_core_tb.sv
`timescale 1ns / 1ps
module channel_duration_average_table_core_tb;
	import cdat_pkg::*;

	localparam int ENTRIES = 16;

	typedef struct packed {
		logic [1:0]  op;
		logic [32:0] lo;
		logic [32:0] hi;
		logic [31:0] dur;
		logic [39:0] now;
	} item_t;

	typedef struct packed {
		logic ok;
		logic found;
		logic closed;
		logic full;
	} verdict_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [1:0] operation = '0;
	logic [32:0] range_start = '0;
	logic [32:0] range_stop = '0;
	logic [31:0] duration_ms = '0;
	logic [39:0] now_ms = '0;
	logic out_valid;
	logic out_stall = 0;
	logic transmission_ok, average_found, window_closed, table_full;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	channel_duration_average_table_core DUT (.*);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	// predictor state
	logic [31:0] window_ms, minrec_ms;
	logic [32:0] a_lo [ENTRIES];
	logic [32:0] a_hi [ENTRIES];
	logic [23:0] a_cnt [ENTRIES];
	logic [47:0] a_sum [ENTRIES];
	logic a_used [ENTRIES];
	logic [32:0] v_lo [ENTRIES];
	logic [32:0] v_hi [ENTRIES];
	logic [31:0] v_dur [ENTRIES];
	logic v_used [ENTRIES];
	logic [39:0] last_close;
	logic learned;

	item_t pending_items[$];
	verdict_t expected_verdicts[$];
	int errors = 0;
	int send_idle = 11, recv_idle = 49;
	bit hold_off = 0;
	int hold_cnt = 0;
	logic [39:0] clock_ms = 0;
	logic [32:0] keys_lo [8];
	logic [32:0] keys_hi [8];

	function automatic verdict_t predict(item_t it);
		verdict_t r;
		int slot;
		logic [48:0] s;
		logic [40:0] lim;
		logic [47:0] q;
		r = '0;
		slot = -1;
		case (it.op)
			OP_REPORT: begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (a_used[i]) begin
						if (a_lo[i] == it.lo && a_hi[i] == it.hi) begin
							if (a_cnt[i] != COUNT_MAX) a_cnt[i]++;
							s = a_sum[i] + it.dur;
							a_sum[i] = s > SUM_MAX ? SUM_MAX : s[47:0];
							return r;
						end
					end else if (slot < 0) slot = i;
				end
				if (slot < 0) r.full = 1;
				else begin
					a_used[slot] = 1; a_lo[slot] = it.lo; a_hi[slot] = it.hi;
					a_cnt[slot] = 1; a_sum[slot] = it.dur;
				end
			end
			OP_TICK: begin
				lim = last_close + window_ms;
				if (lim <= it.now) begin
					for (int i = 0; i < ENTRIES; i++) begin
						v_used[i] = a_used[i];
						if (a_used[i]) begin
							q = a_sum[i] / (a_cnt[i] == 0 ? 24'd1 : a_cnt[i]);
							v_lo[i] = a_lo[i]; v_hi[i] = a_hi[i];
							v_dur[i] = q > AVG_MAX ? AVG_MAX : q[31:0];
						end
						a_used[i] = 0;
					end
					last_close = it.now;
					learned = 1;
					r.closed = 1;
				end
			end
			OP_QUERY: begin
				for (int i = 0; i < ENTRIES; i++)
					if (v_used[i] && v_lo[i] == it.lo && v_hi[i] == it.hi) begin
						r.found = 1;
						r.ok = v_dur[i] >= minrec_ms;
						return r;
					end
				r.ok = learned;
			end
			default: ;
		endcase
		return r;
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (!in_valid || !in_stall) begin
				if (pending_items.size() > 0 && $urandom_range(99) >= send_idle) begin
					item_t it;
					it = pending_items.pop_front();
					expected_verdicts.push_back(predict(it));
					in_valid <= 1;
					operation <= it.op; range_start <= it.lo; range_stop <= it.hi;
					duration_ms <= it.dur; now_ms <= it.now;
				end else in_valid <= 0;
			end
		end
	end

	// receiver stall, with a counted hold-off
	always @(posedge clk) begin
		if (hold_off) hold_cnt <= 3000;
		else if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
		out_stall <= hold_off || (hold_cnt > 0) || ($urandom_range(99) < recv_idle);
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			verdict_t got, exp;
			got = '{transmission_ok, average_found, window_closed, table_full};
			if (expected_verdicts.size() == 0) begin
				$display("%0t unexpected transfer: actual %b", $time, got);
				errors++;
			end else begin
				exp = expected_verdicts.pop_front();
				if (got.ok !== exp.ok)
					$display("%0t transmission_ok: expected %b actual %b", $time, exp.ok, got.ok);
				if (got.found !== exp.found)
					$display("%0t average_found: expected %b actual %b", $time, exp.found,
						got.found);
				if (got.closed !== exp.closed)
					$display("%0t window_closed: expected %b actual %b", $time, exp.closed,
						got.closed);
				if (got.full !== exp.full)
					$display("%0t table_full: expected %b actual %b", $time, exp.full, got.full);
				if (got !== exp) errors++;
			end
		end
	end

	task automatic apb_write(logic [0:0] reg_idx, logic [31:0] value);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= {reg_idx, 2'b00}; pwdata <= value;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		if (reg_idx == REG_WINDOW) window_ms = value;
		else minrec_ms = value;
	endtask

	task automatic drain();
		while (pending_items.size() > 0 || expected_verdicts.size() > 0 || in_valid)
			@(posedge clk);
		repeat (1000) @(posedge clk);
	endtask

	task automatic add(logic [1:0] op, logic [32:0] lo, logic [32:0] hi,
			logic [31:0] dur, logic [39:0] now);
		pending_items.push_back('{op, lo, hi, dur, now});
	endtask

	function automatic logic [32:0] rand33();
		return {1'($urandom_range(1)), $urandom()};
	endfunction

	task automatic random_phase(int n);
		int k;
		for (int j = 0; j < n; j++) begin
			k = $urandom_range(7);
			case ($urandom_range(9))
				0, 1, 2, 3: add(OP_REPORT, keys_lo[k], keys_hi[k],
					$urandom_range(3) == 0 ? $urandom() : $urandom_range(3000), rand33());
				4: add(OP_REPORT, rand33(), rand33(), $urandom(), {$urandom(), 8'h0});
				5: begin
					clock_ms += $urandom_range(3) == 0 ? 40'($urandom_range(200)) :
						40'($urandom_range(600, 100));
					add(OP_TICK, rand33(), rand33(), $urandom(), clock_ms);
				end
				6, 7, 8: add(OP_QUERY, keys_lo[k], keys_hi[k], $urandom(), {$urandom(), 8'h0});
				default: add(2'($urandom_range(3)), rand33(), rand33(), $urandom(),
					{$urandom(), 8'($urandom_range(255))});
			endcase
		end
	endtask

	initial begin
		window_ms = 60000; minrec_ms = 1000;
		last_close = 0; learned = 0;
		for (int i = 0; i < ENTRIES; i++) begin
			a_used[i] = 0; v_used[i] = 0;
		end
		for (int i = 0; i < 8; i++) begin
			keys_lo[i] = rand33(); keys_hi[i] = rand33();
		end
		keys_lo[0] = '0; keys_hi[0] = '1;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: defaults, then extremes
		add(OP_QUERY, '0, '1, 0, 0);
		add(OP_TICK, 0, 0, 0, 40'd59999);
		add(OP_REPORT, '0, '1, '1, 0);
		add(OP_REPORT, '0, '1, '1, 0);
		add(OP_REPORT, '1, '0, 32'd999, 0);
		add(OP_REPORT, 33'd5, 33'd6, 32'd1000, 0);
		for (int i = 0; i < 14; i++) add(OP_REPORT, 33'(100 + i), 33'(i), 32'd1, 0);
		add(OP_TICK, 0, 0, 0, 40'd60000);
		add(OP_QUERY, '0, '1, 0, 0);
		add(OP_QUERY, '1, '0, 0, 0);
		add(OP_QUERY, 33'd5, 33'd6, 0, 0);
		add(OP_QUERY, 33'd7, 33'd7, 0, 0);
		add(2'd3, '1, '1, '1, '1);
		drain();

		apb_write(REG_WINDOW, '1);
		apb_write(REG_MINREC, '1);
		add(OP_TICK, 0, 0, 0, '1);
		add(OP_QUERY, 33'd5, 33'd6, 0, 0);
		add(OP_TICK, 0, 0, 0, 40'd60000 + 40'hFFFFFFFF);
		drain();

		// random phases, several settings
		apb_write(REG_WINDOW, 0);
		apb_write(REG_MINREC, 0);
		last_close = last_close;
		random_phase(150);
		drain();
		apb_write(REG_WINDOW, 500);
		apb_write(REG_MINREC, 1500);
		random_phase(400);
		drain();
		send_idle = 49; recv_idle = 11;
		apb_write(REG_WINDOW, 1000);
		apb_write(REG_MINREC, 800);
		random_phase(400);
		// long receiver hold-off while the sender keeps offering
		hold_off <= 1;
		@(posedge clk);
		hold_off <= 0;
		drain();
		send_idle = 0; recv_idle = 0;
		apb_write(REG_MINREC, 300);
		random_phase(350);
		drain();

		if (errors == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end

	initial begin
		#20000000;
		$display("Verification failed");
		$finish;
	end
endmodule

FILE: channel_duration_average_table_core.f
rtl/cdat_pkg.sv
rtl/cdat_ram.sv
rtl/cdat_div.sv
rtl/channel_duration_average_table_core.sv
tb/sv/channel_duration_average_table_core_tb.sv
